// ===== sv/dual_kiss_uniform_generator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Dual KISS uniform generator - assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst.
// ----------------------------------------------------------------------------
`ifndef DUAL_KISS_UNIFORM_GENERATOR_TOP_ASSERT_SVH
`define DUAL_KISS_UNIFORM_GENERATOR_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset
`define DKUG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked from the edge after the trigger
`define DKUG_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// ===== sv/dkug_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkug_pkg
// Types, constants and helper functions for the dual KISS generator.
// ----------------------------------------------------------------------------
package dkug_pkg;

  localparam int unsigned NUM_WORDS  = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned SEED_W     = 32;
  localparam int unsigned FRAC_W     = 53;
  localparam int unsigned OUT_DATA_W = 120;

  localparam logic [31:0] LCG_MULT  = 32'd69069;
  localparam logic [31:0] LCG_INC   = 32'd1327217885;
  localparam logic [31:0] MWC1_MULT = 32'd18000;
  localparam logic [31:0] MWC2_MULT = 32'd30903;
  localparam logic [31:0] SEED_MULT = 32'd36969;

  // Request kinds carried on s_tuser
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  localparam logic [31:0] RESET_WORDS [NUM_WORDS] = '{
    32'd123456789, 32'd362436069, 32'd521288629, 32'd316191069,
    32'd987654321, 32'd458629013, 32'd582859209, 32'd438195021
  };

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_SEED = 3'b100
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             step;       // advance both generators
    logic             load_seed;  // capture seed into iteration register
    logic             seed_iter;  // one seed iteration, write two half words
    logic             load_out;   // register the sum of the stepped state
    logic [IDX_W-1:0] idx;        // seed iteration number
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } status_t;

  // 16-bit multiply-with-carry step
  function automatic logic [31:0] mwc_step(input logic [31:0] w, input logic [31:0] mult);
    return 32'({16'd0, w[15:0]} * mult) + {16'd0, w[31:16]};
  endfunction

  // 13/17/5 xorshift step
  function automatic logic [31:0] xsh_step(input logic [31:0] w);
    logic [31:0] s;
    s = w;
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    return s;
  endfunction

  // Seed iteration, arithmetic shift of the upper half
  function automatic logic [31:0] seed_step(input logic [31:0] p);
    return 32'({16'd0, p[15:0]} * SEED_MULT) + {{16{p[31]}}, p[31:16]};
  endfunction

endpackage

// ===== sv/dkug_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkug_ctrl
// Request sequencer: accepts draw and reseed transactions and drives the
// datapath through the step, sum and seed sequences.
// ----------------------------------------------------------------------------
`include "dual_kiss_uniform_generator_top_assert.svh"

module dkug_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,   // [0] req_type
  input  dkug_pkg::status_t       status,
  output dkug_pkg::cmd_t          cmd
);
  import dkug_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             accept;

  // No transaction is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.idx       = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == REQ_RESEED) begin
            cmd.load_seed = 1'b1;
            cnt_next      = '0;
            state_next    = ST_SEED;
          end else begin
            cmd.step   = 1'b1;
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SEED: begin
        cmd.seed_iter = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == IDX_W'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `DKUG_ASSERT_NEXT(a_draw_to_sum, accept && (s_tuser == REQ_DRAW), state == ST_SUM,
    "draw transaction did not move to sum state")
  `DKUG_ASSERT_NEXT(a_seed_count, (state == ST_SEED) && (cnt != IDX_W'(NUM_WORDS - 1)),
    (state == ST_SEED) && (cnt == $past(cnt) + 1'b1), "seed sequence skipped a step")
  `DKUG_ASSERT_NEXT(a_seed_done, (state == ST_SEED) && (cnt == IDX_W'(NUM_WORDS - 1)),
    state == ST_IDLE, "seed sequence did not end after eight steps")

endmodule

// ===== sv/dkug_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkug_datapath
// Generator state words, seed iteration register and result register.
// ----------------------------------------------------------------------------
`include "dual_kiss_uniform_generator_top_assert.svh"

module dkug_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dkug_pkg::cmd_t                      cmd,
  output dkug_pkg::status_t                   status,
  input  logic [dkug_pkg::SEED_W-1:0]         s_tdata,  // [31:0] seed_value (signed)
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dkug_pkg::OUT_DATA_W-1:0]     m_tdata   // [52:0] fraction,
                                                        // [84:53] first_word,
                                                        // [116:85] second_word
);
  import dkug_pkg::*;

  logic [31:0] gen   [NUM_WORDS];
  logic [31:0] gen_next [NUM_WORDS];
  logic [31:0] p;
  logic [31:0] p_next;
  logic [31:0] u, v;
  logic [IDX_W-1:0] lo_idx, hi_idx;

  // One KISS step for both generators
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      gen_next[4*g]     = gen[4*g] * LCG_MULT + LCG_INC;
      gen_next[4*g + 1] = xsh_step(gen[4*g + 1]);
      gen_next[4*g + 2] = mwc_step(gen[4*g + 2], MWC1_MULT);
      gen_next[4*g + 3] = mwc_step(gen[4*g + 3], MWC2_MULT);
    end
  end

  // Seed iteration; iteration i fills half (i & 1) of words i/2 and 4 + i/2
  assign p_next = seed_step(p);
  assign lo_idx = {1'b0, cmd.idx[IDX_W-1:1]};
  assign hi_idx = {1'b1, cmd.idx[IDX_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        gen[k] <= RESET_WORDS[k];
      end
    end else if (cmd.step) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        gen[k] <= gen_next[k];
      end
    end else if (cmd.seed_iter) begin
      if (cmd.idx[0]) begin
        gen[lo_idx][31:16] <= {p_next[23:16], p_next[7:0]};
        gen[hi_idx][31:16] <= {p_next[31:24], p_next[15:8]};
      end else begin
        gen[lo_idx][15:0]  <= {p_next[23:16], p_next[7:0]};
        gen[hi_idx][15:0]  <= {p_next[31:24], p_next[15:8]};
      end
    end
  end

  // Seed iteration register
  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      p <= s_tdata;
    end else if (cmd.seed_iter) begin
      p <= p_next;
    end
  end

  // KISS outputs from the stepped state
  assign u = gen[0] + gen[1] + {gen[2][15:0], 16'd0} + gen[3];
  assign v = gen[4] + gen[5] + {gen[6][15:0], 16'd0} + gen[7];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {3'd0, v, u, u, v[31:11]};
    end
  end

  assign status.out_busy = m_tvalid && !m_tready;

  `DKUG_ASSERT(a_no_overwrite, !(cmd.load_out && m_tvalid && !m_tready),
    "pending result overwritten")
  `DKUG_ASSERT_NEXT(a_load_valid, cmd.load_out, m_tvalid,
    "loaded result not presented")
  `DKUG_ASSERT(a_cmd_excl, !(cmd.step && cmd.seed_iter),
    "step and seed iteration issued together")

endmodule

// ===== sv/dual_kiss_uniform_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_kiss_uniform_generator_top
// Two KISS generators with draw and reseed requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): s_tuser[0] is the request kind, 0 = draw, 1 = reseed;
//   s_tdata carries the signed 32-bit seed, read on reseed only.
//   Output stream (m_*): one transaction per draw, none per reseed;
//   m_tdata holds fraction, first_word and second_word.
//   A draw steps both generators at the accepting edge, forms the sum in the
//   next cycle and loads it into the result register once that register is
//   free; the load raises m_tvalid. A draw holds the sequencer for its step
//   cycle and its sum cycle; no new request is taken until it is done.
//   A reseed runs the seed multiply-with-carry unit once per cycle, writing
//   two half words each cycle until all eight state words are refilled.
//   No new request is taken until the reseed ends. Reset loads the two
//   default seed quadruples and empties the result register; s_tready stays
//   low during reset and the block is ready as soon as reset is released.
//   When the receiver stalls, the result holds in its register; requests are
//   still accepted until the next draw, which then waits in its sum cycle
//   until the register frees.
// ----------------------------------------------------------------------------

module dual_kiss_uniform_generator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] seed_value (signed)
  input  logic [0:0]   s_tuser,   // [0] req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata    // [52:0] fraction, [84:53] first_word,
                                  // [116:85] second_word, [119:117] zero
);
  import dkug_pkg::*;

  cmd_t    cmd;
  status_t status;

  dkug_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  dkug_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
